// ===== src/sams_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sams_pkg
// Types, codes and default sizes shared by the multi-stack core.
// ----------------------------------------------------------------------------
package sams_pkg;

    // Default sizes of the shared word memory and of the stack table.
    localparam int STORE_WORDS_DEF = 256;
    localparam int MAX_STACKS_DEF  = 8;

    // Fixed field widths of the request and result words.
    localparam int ID_W      = 3;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 3;
    localparam int ADDR_O_W  = 8;
    localparam int COUNT_W   = 4;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;
    localparam int CFG_W     = 32;
    localparam int PADDR_W   = 3;

    // Register index decoded from paddr[2].
    localparam logic REG_STACK_COUNT = 1'b0;

    // Request kinds.
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OWN   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OTHER = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADID = 3'd4;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_DIV,
        S_MAP,
        S_IDLE,
        S_WORK,
        S_POP
    } t_state;

endpackage : sams_pkg
`default_nettype wire

// ===== src/shared_array_multi_stack_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The core takes a new request only in the idle state, so it serves one word at a time;
//   an overflow search tries each full stack in turn, and a pop waits for the
//   registered memory read before its result is written.
// Reset and every stack_count write empty all stacks and repartition the memory;
//   memory is not cleared.
// ----------------------------------------------------------------------------
// shared_array_multi_stack_core
// Several LIFO stacks in one shared word memory, with overflow into the next
// stack that has room, controlled by a small sequencer.
// ----------------------------------------------------------------------------
module shared_array_multi_stack_core #(
    parameter int STORE_WORDS = sams_pkg::STORE_WORDS_DEF,
    parameter int MAX_STACKS  = sams_pkg::MAX_STACKS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Request stream.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata fields from bit 0: stack_sel[2:0], push_value[34:3], zero fill[39:35].
    input  wire logic [sams_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser fields from bit 0: req_type[0].
    input  wire logic                            s_tuser,
    // Result stream.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata fields from bit 0: used_stack[2:0], used_address[10:3],
    // pop_value[42:11], zero fill[47:43].
    output logic [sams_pkg::M_TDATA_W-1:0]       m_tdata,
    // m_tuser fields from bit 0: status[2:0].
    output logic [sams_pkg::STATUS_W-1:0]        m_tuser,
    // Configuration port.
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sams_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [sams_pkg::CFG_W-1:0]      pwdata,
    output logic [sams_pkg::CFG_W-1:0]           prdata,
    output logic                                 pready
);

    // Address, fill/capacity, stack index and divider bit counter widths.
    localparam int AW = $clog2(STORE_WORDS);
    localparam int QW = AW + 1;
    localparam int SW = $clog2(MAX_STACKS);
    localparam int BW = $clog2(QW);
    localparam int CW = sams_pkg::COUNT_W;
    localparam logic [QW-1:0] DIVIDEND = QW'(STORE_WORDS);
    localparam logic [SW-1:0] LAST_IDX = SW'(MAX_STACKS - 1);

    // Sequencer and stack table.
    sams_pkg::t_state r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [QW-1:0]  r_fill  [MAX_STACKS];
    logic [QW-1:0]  n_fill  [MAX_STACKS];
    logic [AW-1:0]  r_start [MAX_STACKS];
    logic [AW-1:0]  n_start [MAX_STACKS];
    logic [QW-1:0]  r_cap   [MAX_STACKS];
    logic [QW-1:0]  n_cap   [MAX_STACKS];

    // Partition divider and region mapper.
    logic [BW-1:0]  r_bit, n_bit;
    logic [CW-1:0]  r_rem, n_rem;
    logic [QW-1:0]  r_chunk, n_chunk;
    logic [SW-1:0]  r_map_idx, n_map_idx;
    logic [QW-1:0]  r_acc, n_acc;

    // Request being served.
    logic                              r_op, n_op;
    logic [sams_pkg::ID_W-1:0]         r_id, n_id;
    logic [sams_pkg::VALUE_W-1:0]      r_value, n_value;
    logic [SW-1:0]                     r_cursor, n_cursor;
    logic [CW-1:0]                     r_tries, n_tries;
    logic [AW-1:0]                     r_addr, n_addr;

    // Output register.
    logic                              r_out_valid, n_out_valid;
    logic [sams_pkg::STATUS_W-1:0]     r_out_status, n_out_status;
    logic [sams_pkg::ID_W-1:0]         r_out_stack, n_out_stack;
    logic [sams_pkg::ADDR_O_W-1:0]     r_out_addr, n_out_addr;
    logic [sams_pkg::VALUE_W-1:0]      r_out_value, n_out_value;

    // Shared word memory.
    logic [sams_pkg::VALUE_W-1:0]      r_mem [STORE_WORDS];
    logic [sams_pkg::VALUE_W-1:0]      r_rdata;
    logic                              mem_we;
    logic                              mem_re;
    logic [AW-1:0]                     mem_addr;

    // Combinational helpers.
    logic                cfg_we;
    logic [CW-1:0]       cfg_count;
    logic                accept;
    logic                can_emit;
    logic [CW:0]         div_try;
    logic                div_q;
    logic [QW-1:0]       sel_fill;
    logic [AW-1:0]       sel_start;
    logic [QW-1:0]       sel_cap;
    logic                bad_id;
    logic [AW-1:0]       push_addr;
    logic [AW-1:0]       pop_addr;

    // ------------------------------------------------------------------
    // Configuration port. Writes beyond the single register are ignored.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == sams_pkg::REG_STACK_COUNT);
    assign prdata = (paddr[2] == sams_pkg::REG_STACK_COUNT) ? sams_pkg::CFG_W'(r_count) : '0;

    // A count of zero is taken as one, and a count above the table size is clipped.
    always_comb begin
        if (pwdata[CW-1:0] == '0) begin
            cfg_count = CW'(1);
        end else if (5'(pwdata[CW-1:0]) > 5'(MAX_STACKS)) begin
            cfg_count = CW'(MAX_STACKS);
        end else begin
            cfg_count = pwdata[CW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshake and datapath helpers.
    // ------------------------------------------------------------------
    assign s_tready = i_rst_n && (r_state == sams_pkg::S_IDLE) && !cfg_we;
    assign accept   = s_tvalid && s_tready;
    // The output register can take a new result when it is empty or being drained.
    assign can_emit = !r_out_valid || m_tready;

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out_status;
    assign m_tdata  = {5'b0, r_out_value, r_out_addr, r_out_stack};

    // One restoring division step of STORE_WORDS by the stack count.
    assign div_try = {r_rem, DIVIDEND[r_bit]};
    assign div_q   = (div_try >= {1'b0, r_count});

    // The stack under the cursor feeds the fill compares and the push and pop address adders.
    assign sel_fill  = r_fill[r_cursor];
    assign sel_start = r_start[r_cursor];
    assign sel_cap   = r_cap[r_cursor];
    assign bad_id    = (CW'(r_id) >= r_count);
    assign push_addr = AW'(QW'(sel_start) + sel_fill);
    assign pop_addr  = AW'(QW'(sel_start) + sel_fill - QW'(1));

    // ------------------------------------------------------------------
    // Next state and outputs.
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_fill       = r_fill;
        n_start      = r_start;
        n_cap        = r_cap;
        n_bit        = r_bit;
        n_rem        = r_rem;
        n_chunk      = r_chunk;
        n_map_idx    = r_map_idx;
        n_acc        = r_acc;
        n_op         = r_op;
        n_id         = r_id;
        n_value      = r_value;
        n_cursor     = r_cursor;
        n_tries      = r_tries;
        n_addr       = r_addr;
        n_out_valid  = r_out_valid && !m_tready;
        n_out_status = r_out_status;
        n_out_stack  = r_out_stack;
        n_out_addr   = r_out_addr;
        n_out_value  = r_out_value;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_addr     = push_addr;

        unique case (r_state)
            sams_pkg::S_DIV: begin
                n_rem   = div_q ? CW'(div_try - {1'b0, r_count}) : CW'(div_try);
                n_chunk = {r_chunk[QW-2:0], div_q};
                if (r_bit == '0) begin
                    n_state   = sams_pkg::S_MAP;
                    n_map_idx = '0;
                    n_acc     = '0;
                end else begin
                    n_bit = r_bit - BW'(1);
                end
            end
            sams_pkg::S_MAP: begin
                // Region i starts at i * chunk; the last region also gets the remainder.
                if (5'(r_map_idx) < 5'(r_count)) begin
                    n_start[r_map_idx] = AW'(r_acc);
                    if (5'(r_map_idx) + 5'd1 == 5'(r_count)) begin
                        n_cap[r_map_idx] = r_chunk + QW'(r_rem);
                    end else begin
                        n_cap[r_map_idx] = r_chunk;
                    end
                    n_acc = r_acc + r_chunk;
                end else begin
                    n_start[r_map_idx] = '0;
                    n_cap[r_map_idx]   = '0;
                end
                if (r_map_idx == LAST_IDX) begin
                    n_state = sams_pkg::S_IDLE;
                end else begin
                    n_map_idx = r_map_idx + SW'(1);
                end
            end
            sams_pkg::S_IDLE: begin
                if (accept) begin
                    n_op     = s_tuser;
                    n_id     = s_tdata[sams_pkg::ID_W-1:0];
                    n_value  = s_tdata[sams_pkg::ID_W +: sams_pkg::VALUE_W];
                    n_cursor = SW'(s_tdata[sams_pkg::ID_W-1:0]);
                    n_tries  = '0;
                    n_state  = sams_pkg::S_WORK;
                end
            end
            sams_pkg::S_WORK: begin
                if (can_emit) begin
                    if (bad_id) begin
                        n_out_valid  = 1'b1;
                        n_out_status = sams_pkg::ST_BADID;
                        n_out_stack  = r_id;
                        n_out_addr   = '0;
                        n_out_value  = '0;
                        n_state      = sams_pkg::S_IDLE;
                    end else if (r_op == sams_pkg::REQ_POP) begin
                        if (sel_fill == '0) begin
                            n_out_valid  = 1'b1;
                            n_out_status = sams_pkg::ST_EMPTY;
                            n_out_stack  = r_id;
                            n_out_addr   = '0;
                            n_out_value  = '0;
                            n_state      = sams_pkg::S_IDLE;
                        end else begin
                            mem_re             = 1'b1;
                            mem_addr           = pop_addr;
                            n_addr             = pop_addr;
                            n_fill[r_cursor]   = sel_fill - QW'(1);
                            n_state            = sams_pkg::S_POP;
                        end
                    end else if (sel_fill < sel_cap) begin
                        mem_we           = 1'b1;
                        n_fill[r_cursor] = sel_fill + QW'(1);
                        n_out_valid      = 1'b1;
                        n_out_status     = (r_tries == '0) ? sams_pkg::ST_OWN
                                                           : sams_pkg::ST_OTHER;
                        n_out_stack      = sams_pkg::ID_W'(r_cursor);
                        n_out_addr       = sams_pkg::ADDR_O_W'(push_addr);
                        n_out_value      = '0;
                        n_state          = sams_pkg::S_IDLE;
                    end else if (5'(r_tries) + 5'd1 == 5'(r_count)) begin
                        // Every stack in use has been tried.
                        n_out_valid  = 1'b1;
                        n_out_status = sams_pkg::ST_FULL;
                        n_out_stack  = r_id;
                        n_out_addr   = '0;
                        n_out_value  = '0;
                        n_state      = sams_pkg::S_IDLE;
                    end else begin
                        n_tries = r_tries + CW'(1);
                        if (5'(r_cursor) + 5'd1 == 5'(r_count)) begin
                            n_cursor = '0;
                        end else begin
                            n_cursor = r_cursor + SW'(1);
                        end
                    end
                end
            end
            sams_pkg::S_POP: begin
                if (can_emit) begin
                    n_out_valid  = 1'b1;
                    n_out_status = sams_pkg::ST_OWN;
                    n_out_stack  = sams_pkg::ID_W'(r_cursor);
                    n_out_addr   = sams_pkg::ADDR_O_W'(r_addr);
                    n_out_value  = r_rdata;
                    n_state      = sams_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sams_pkg::S_IDLE;
            end
        endcase

        // A count write empties every stack and starts a new partition.
        if (cfg_we) begin
            n_count = cfg_count;
            for (int i = 0; i < MAX_STACKS; i++) begin
                n_fill[i] = '0;
            end
            n_state = sams_pkg::S_DIV;
            n_bit   = BW'(QW - 1);
            n_rem   = '0;
            n_chunk = '0;
        end
    end

    // ------------------------------------------------------------------
    // State registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sams_pkg::S_DIV;
            r_count     <= CW'(1);
            for (int i = 0; i < MAX_STACKS; i++) begin
                r_fill[i] <= '0;
            end
            r_bit       <= BW'(QW - 1);
            r_rem       <= '0;
            r_chunk     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_fill      <= n_fill;
            r_bit       <= n_bit;
            r_rem       <= n_rem;
            r_chunk     <= n_chunk;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_start      <= n_start;
        r_cap        <= n_cap;
        r_map_idx    <= n_map_idx;
        r_acc        <= n_acc;
        r_op         <= n_op;
        r_id         <= n_id;
        r_value      <= n_value;
        r_cursor     <= n_cursor;
        r_tries      <= n_tries;
        r_addr       <= n_addr;
        r_out_status <= n_out_status;
        r_out_stack  <= n_out_stack;
        r_out_addr   <= n_out_addr;
        r_out_value  <= n_out_value;
    end

    // Shared word memory with a registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= r_value;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // An accepted word is always worked on in the following cycle.
    a_accept_to_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == sams_pkg::S_WORK))
        else $error("accepted request did not enter the work state");

    // A stack never holds more words than its region.
    a_fill_in_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sams_pkg::S_WORK && !bad_id) |-> (sel_fill <= sel_cap))
        else $error("stack fill exceeds its region");

    // A count write restarts the partition; the stack under the cursor is then empty.
    a_cfg_repartition: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_we |=> (r_state == sams_pkg::S_DIV && sel_fill == '0))
        else $error("count write did not restart the partition");

    // Only a successful pop carries a nonzero value.
    a_value_only_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != sams_pkg::ST_OWN) |-> (r_out_value == '0))
        else $error("nonzero pop value on a result that is not a pop");

endmodule : shared_array_multi_stack_core
`default_nettype wire
